[design/hshome_pkg.sv]
// shared types and constants for the hall sensor homing sequencer
`default_nettype none
package hshome_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CFG_BITS   = 16;
    // compare width wide enough for both the count and the threshold plus one
    localparam int CMP_BITS   = ((COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS) + 1;

    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 8;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CFG_BITS-1:0]   cfg_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_FIND    = 3'd1,
        MODE_LEAVE   = 3'd2,
        MODE_INFIELD = 3'd3,
        MODE_CENTER  = 3'd4,
        MODE_DONE    = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_FWD  = 2'd1,
        CMD_BACK = 2'd2
    } step_cmd_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef struct packed {
        logic      calibrated;
        logic      position_reset;
        step_cmd_t step_command;
    } result_t;

endpackage
`default_nettype wire

[design/hshome_fsm.sv]
// homing state machine: mode and step count update for one item
`default_nettype none
module hshome_fsm (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire hshome_pkg::cfg_t     cfg_wr_data,
    input  wire logic                 step_en,
    input  wire hshome_pkg::op_t      operation,
    input  wire logic                 hall_active,
    output hshome_pkg::result_t       result
);

    hshome_pkg::mode_t  mode_reg, mode_next;
    hshome_pkg::count_t count_reg, count_next;
    hshome_pkg::cfg_t   min_out_reg;

    logic [hshome_pkg::CMP_BITS-1:0] lim_ext;
    logic [hshome_pkg::CMP_BITS-1:0] lim_plus;
    logic [hshome_pkg::CMP_BITS-1:0] cnt_ext;
    logic [hshome_pkg::CMP_BITS-1:0] cnt_max_ext;
    hshome_pkg::count_t              cnt_inc;
    hshome_pkg::count_t              leave_start;
    logic                            cnt_full;
    logic                            cnt_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= hshome_pkg::MODE_IDLE;
            count_reg   <= '0;
            min_out_reg <= hshome_pkg::CFG_BITS'(20);
        end else begin
            if (cfg_wr_en) begin
                min_out_reg <= cfg_wr_data;
            end
            if (step_en) begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
            end
        end
    end

    always_comb begin
        lim_ext     = hshome_pkg::CMP_BITS'(min_out_reg);
        lim_plus    = lim_ext + hshome_pkg::CMP_BITS'(1);
        cnt_ext     = hshome_pkg::CMP_BITS'(count_reg);
        cnt_max_ext = hshome_pkg::CMP_BITS'({hshome_pkg::COUNT_BITS{1'b1}});
        cnt_full    = (count_reg == {hshome_pkg::COUNT_BITS{1'b1}});
        cnt_zero    = (count_reg == '0);
        cnt_inc     = cnt_full ? count_reg : count_reg + hshome_pkg::COUNT_BITS'(1);
        // threshold plus one, clamped to the counter range
        leave_start = (lim_plus > cnt_max_ext) ? {hshome_pkg::COUNT_BITS{1'b1}}
                                               : lim_plus[hshome_pkg::COUNT_BITS-1:0];
    end

    always_comb begin
        mode_next = mode_reg;
        count_next = count_reg;
        result = '{calibrated: 1'b0, position_reset: 1'b0,
                   step_command: hshome_pkg::CMD_NONE};
        if (operation == hshome_pkg::OP_START) begin
            count_next = '0;
            mode_next  = hshome_pkg::MODE_FIND;
        end else begin
            unique case (mode_reg)
                hshome_pkg::MODE_DONE: begin
                    result.calibrated = 1'b1;
                end
                hshome_pkg::MODE_FIND: begin
                    if (hall_active && (cnt_ext <= lim_ext)) begin
                        // started inside the field: back out first
                        count_next = leave_start;
                        mode_next  = hshome_pkg::MODE_LEAVE;
                    end else if (hall_active) begin
                        count_next = '0;
                        mode_next  = hshome_pkg::MODE_INFIELD;
                    end else begin
                        result.step_command = hshome_pkg::CMD_FWD;
                        count_next = cnt_inc;
                    end
                end
                hshome_pkg::MODE_LEAVE: begin
                    if (cnt_zero) begin
                        mode_next = hshome_pkg::MODE_FIND;
                    end else begin
                        result.step_command = hshome_pkg::CMD_BACK;
                        if (!hall_active) begin
                            count_next = count_reg - hshome_pkg::COUNT_BITS'(1);
                        end
                    end
                end
                hshome_pkg::MODE_INFIELD: begin
                    if (!hall_active) begin
                        mode_next  = hshome_pkg::MODE_CENTER;
                        count_next = count_reg >> 1;
                    end else begin
                        result.step_command = hshome_pkg::CMD_FWD;
                        count_next = cnt_inc;
                    end
                end
                hshome_pkg::MODE_CENTER: begin
                    if (cnt_zero) begin
                        mode_next = hshome_pkg::MODE_DONE;
                        result.position_reset = 1'b1;
                    end else begin
                        result.step_command = hshome_pkg::CMD_BACK;
                        count_next = count_reg - hshome_pkg::COUNT_BITS'(1);
                    end
                end
                hshome_pkg::MODE_IDLE: begin
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[design/hall_sensor_homing_fsm_unit.sv]
// top level of the hall sensor homing sequencer: input register, fsm, result register
//
//   channel   dir   ports                    contents
//   s_        in    tvalid tready tdata tuser tdata[0] hall_active, tuser[0] operation
//   m_        out   tvalid tready tdata       step_command, position_reset, calibrated
//   cfg_      in    wr_en wr_data            min_steps_outside, written when wr_en is high
//
// one item per cycle while m_ is not stalled; an accepted item passes through the
// input register and then the result register before it appears on m_.
// the fsm advances only when the input register holds an item and the result
// register is free or being drained, so stalls on m_ back up to s_tready.
// reset clears mode, step count, valid flags and sets min_steps_outside to 20.
`default_nettype none
module hall_sensor_homing_fsm_unit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [hshome_pkg::CFG_BITS-1:0]       cfg_wr_data,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // [0] hall_active, [7:1] zero
    input  wire logic [hshome_pkg::IN_TDATA_BITS-1:0]  s_tdata,
    // [0] operation
    input  wire logic                                  s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // [1:0] step_command, [2] position_reset, [3] calibrated, [7:4] zero
    output logic [hshome_pkg::OUT_TDATA_BITS-1:0]      m_tdata
);

    logic                in_valid_reg;
    hshome_pkg::op_t     in_op_reg;
    logic                in_hall_reg;
    logic                out_valid_reg;
    hshome_pkg::result_t out_res_reg;
    hshome_pkg::result_t fsm_res;
    logic                advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= hshome_pkg::op_t'(s_tuser);
            in_hall_reg <= s_tdata[0];
        end
        if (advance) begin
            out_res_reg <= fsm_res;
        end
    end

    hshome_fsm u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (advance),
        .operation   (in_op_reg),
        .hall_active (in_hall_reg),
        .result      (fsm_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = hshome_pkg::OUT_TDATA_BITS'(out_res_reg);

endmodule
`default_nettype wire

[tb/sv/tb_hall_sensor_homing_fsm_unit.sv]
// testbench for the hall sensor homing sequencer: directed table and random episodes
`default_nettype none
module tb_hall_sensor_homing_fsm_unit;
    import hshome_pkg::*;

    localparam int     CYCLE_LIMIT = 2000000;
    localparam int     HOLD_CYCLES = 80;
    localparam int     DRAIN_WAIT  = 4;
    localparam int     PHASE_ITEMS = 115;
    localparam count_t COUNT_MAX   = {COUNT_BITS{1'b1}};

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t kind;
        op_t       op;
        logic      hall;
        logic      typed;
        result_t   want;
        cfg_t      value;
    } plan_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_BITS-1:0]       cfg_wr_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
    logic                      s_tuser = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;

    // predictor state
    mode_t  homing_mode = MODE_IDLE;
    count_t homing_steps = '0;
    cfg_t   min_outside = cfg_t'(20);

    result_t   step_results_due[$];
    plan_row_t directed_plan[$];
    int        items_sent = 0;
    int        fail_count = 0;
    int        cycle_count = 0;
    bit        sender_gaps = 1'b0;
    bit        receiver_stalls = 1'b0;
    bit        hold_off_req = 1'b0;

    hall_sensor_homing_fsm_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic result_t predict_homing_step(op_t op, logic hall);
        result_t    r;
        logic [16:0] leave_count;
        r = '0;
        r.step_command = CMD_NONE;
        if (op == OP_START) begin
            homing_steps = '0;
            homing_mode  = MODE_FIND;
        end else begin
            case (homing_mode)
                MODE_DONE: begin
                    r.calibrated = 1'b1;
                end
                MODE_FIND: begin
                    if (hall && ({1'b0, homing_steps} <= {1'b0, min_outside})) begin
                        leave_count  = {1'b0, min_outside} + 17'd1;
                        homing_steps = (leave_count > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                                         : leave_count[15:0];
                        homing_mode  = MODE_LEAVE;
                    end else if (hall) begin
                        homing_steps = '0;
                        homing_mode  = MODE_INFIELD;
                    end else begin
                        r.step_command = CMD_FWD;
                        if (homing_steps != COUNT_MAX) homing_steps = homing_steps + 1'b1;
                    end
                end
                MODE_LEAVE: begin
                    if (homing_steps == '0) begin
                        homing_mode = MODE_FIND;
                    end else begin
                        r.step_command = CMD_BACK;
                        if (!hall) homing_steps = homing_steps - 1'b1;
                    end
                end
                MODE_INFIELD: begin
                    if (!hall) begin
                        homing_mode  = MODE_CENTER;
                        homing_steps = homing_steps >> 1;
                    end else begin
                        r.step_command = CMD_FWD;
                        if (homing_steps != COUNT_MAX) homing_steps = homing_steps + 1'b1;
                    end
                end
                MODE_CENTER: begin
                    if (homing_steps == '0) begin
                        homing_mode      = MODE_DONE;
                        r.position_reset = 1'b1;
                    end else begin
                        homing_steps   = homing_steps - 1'b1;
                        r.step_command = CMD_BACK;
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 15) < 13) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_row(row_kind_t kind, op_t op, logic hall, logic typed,
                           step_cmd_t cmd, logic preset, logic cal, cfg_t value);
        plan_row_t row;
        row.kind                = kind;
        row.op                  = op;
        row.hall                = hall;
        row.typed               = typed;
        row.want.step_command   = cmd;
        row.want.position_reset = preset;
        row.want.calibrated     = cal;
        row.value               = value;
        directed_plan.push_back(row);
    endtask

    // called at a rising edge; leaves valid high unless a gap follows
    task automatic send_item(op_t op, logic hall, logic typed, result_t want);
        result_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_BITS-1){1'b0}}, hall};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_homing_step(op, hall);
        step_results_due.push_back(typed ? want : predicted);
        items_sent++;
        if (sender_gaps && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge aclk);
        end
    endtask

    task automatic send_tick(logic hall);
        send_item(OP_TICK, hall, 1'b0, '0);
    endtask

    task automatic wait_drained();
        while (step_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // only with the sender quiet and every result back
    task automatic load_threshold(cfg_t value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        min_outside = value;
    endtask

    // one homing attempt (or a burst of noise): maybe start inside the field, approach, cross it, center
    task automatic run_episode();
        int n;
        if ($urandom_range(0, 4) == 0) begin
            // noise and broken sequences
            n = $urandom_range(3, 12);
            repeat (n) begin
                send_item(($urandom_range(0, 7) == 0) ? OP_START : OP_TICK,
                          1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end else begin
            if ($urandom_range(0, 7) != 0) send_item(OP_START, 1'($urandom_range(0, 1)), 1'b0, '0);
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) send_tick(1'b1);
            n = $urandom_range(0, int'(min_outside) + 6);
            repeat (n) send_tick(1'b0);
            repeat ($urandom_range(1, 12)) send_tick(1'b1);
            repeat ($urandom_range(1, 16)) send_tick(1'b0);
            repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            if (fail_count < 50) $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[3:0]);
            if (step_results_due.size() == 0) begin
                $error("result transfer with no expectation pending: %h", m_tdata);
                fail_count++;
            end else begin
                want = step_results_due.pop_front();
                check_field("step_command", int'(want.step_command), int'(got.step_command));
                check_field("position_reset", int'(want.position_reset),
                            int'(got.position_reset));
                check_field("calibrated", int'(want.calibrated), int'(got.calibrated));
                check_field("tdata padding", 0, int'(m_tdata[OUT_TDATA_BITS-1:4]));
            end
        end
    end

    // result side: ready, random stalls, or a long hold-off on request
    initial begin
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (pick_gap()) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL hall_sensor_homing_fsm_unit");
        $finish;
    end

    initial begin
        cfg_t phase_threshold[5];
        int   phase_end;
        int   episode;

        // idle ticks, a full pass at threshold zero, back-out, restart mid-search
        add_row(ROW_ITEM, OP_TICK,  1'b0, 1'b1, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b1, 1'b1, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_START, 1'b1, 1'b1, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b0, 1'b0, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_CFG,  OP_TICK,  1'b0, 1'b0, CMD_NONE, 1'b0, 1'b0, cfg_t'(0));
        add_row(ROW_ITEM, OP_TICK,  1'b1, 1'b0, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b1, 1'b0, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b1, 1'b0, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b1, 1'b0, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b0, 1'b0, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b0, 1'b0, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b1, 1'b1, CMD_NONE, 1'b1, 1'b0, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b0, 1'b1, CMD_NONE, 1'b0, 1'b1, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b1, 1'b1, CMD_NONE, 1'b0, 1'b1, '0);
        add_row(ROW_ITEM, OP_START, 1'b0, 1'b1, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b1, 1'b0, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b1, 1'b0, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b0, 1'b0, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b1, 1'b0, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b0, 1'b0, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_START, 1'b1, 1'b1, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_CFG,  OP_TICK,  1'b0, 1'b0, CMD_NONE, 1'b0, 1'b0, cfg_t'(65534));
        add_row(ROW_ITEM, OP_TICK,  1'b0, 1'b0, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_TICK,  1'b1, 1'b0, CMD_NONE, 1'b0, 1'b0, '0);
        add_row(ROW_ITEM, OP_START, 1'b0, 1'b1, CMD_NONE, 1'b0, 1'b0, '0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_CFG) begin
                s_tvalid <= 1'b0;
                load_threshold(directed_plan[i].value);
            end else begin
                send_item(directed_plan[i].op, directed_plan[i].hall,
                          directed_plan[i].typed, directed_plan[i].want);
            end
        end
        s_tvalid <= 1'b0;

        phase_threshold[0] = cfg_t'(20);
        phase_threshold[1] = cfg_t'(0);
        phase_threshold[2] = cfg_t'(3);
        phase_threshold[3] = cfg_t'(1);
        phase_threshold[4] = cfg_t'($urandom_range(2, 9));
        foreach (phase_threshold[p]) begin
            load_threshold(phase_threshold[p]);
            sender_gaps     = (p != 2);
            receiver_stalls = (p != 3);
            phase_end = items_sent + PHASE_ITEMS;
            episode   = 0;
            while (items_sent < phase_end) begin
                // block fills up while the result side holds off
                if (p == 1 && episode == 2) begin
                    sender_gaps  = 1'b0;
                    hold_off_req = 1'b1;
                end
                if (p == 1 && episode == 4) sender_gaps = 1'b1;
                run_episode();
                episode++;
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS hall_sensor_homing_fsm_unit");
        end else begin
            $display("FAIL hall_sensor_homing_fsm_unit");
        end
        $finish;
    end

endmodule
`default_nettype wire
